[hdl/mfcda_pkg.sv]
// ----------------------------------------------------------------------------
// mfcda_pkg
// Shared types and constants for the minifloat convert/double/add unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mfcda_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned ExpWidth  = 5;
   localparam int unsigned FracWidth = 26;
   localparam int unsigned MagWidth  = 28;

   localparam logic [ExpWidth-1:0] ExpInf = 5'd31;

   typedef enum logic [1:0] {
      ACT_CONVERT = 2'd0,
      ACT_DOUBLE  = 2'd1,
      ACT_ADD     = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   // Sum stage output for add.
   typedef struct packed {
      logic                sign;
      logic [4:0]          exp;
      logic [MagWidth-1:0] mag;
   } sum_type;

endpackage

`default_nettype wire

[hdl/mfcda_align.sv]
// ----------------------------------------------------------------------------
// mfcda_align
// Stage 1: convert and double finish here; add aligns the two magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module mfcda_align (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic                    in_valid,
   input  wire logic [1:0]              in_action,
   input  wire logic [31:0]             in_a,
   input  wire logic [31:0]             in_b,
   output      logic                    out_valid,
   output      logic                    out_is_add,
   output      logic [31:0]             out_direct,
   output      logic                    out_sa,
   output      logic                    out_sb,
   output      logic [4:0]              out_exp,
   output      logic [26:0]             out_ma,
   output      logic [26:0]             out_mb
);

   logic        valid_ff;
   logic        is_add_ff, is_add_in;
   logic [31:0] direct_ff, direct_in;
   logic        sa_ff, sb_ff;
   logic [4:0]  exp_ff, exp_in;
   logic [26:0] ma_ff, ma_in, mb_ff, mb_in;

   logic [8:0]  conv_e;
   logic [22:0] conv_m;
   logic [4:0]  conv_d;
   logic [31:0] conv_r, dbl_r;
   logic [4:0]  dbl_e;
   logic [26:0] dbl_m;
   logic [4:0]  ea, eb, align_dist;
   logic [26:0] ha, hb;

   always_comb begin
      // Convert: rebias by 112.
      conv_e = {1'b0, in_a[30:23]} - 9'd112;
      conv_m = in_a[22:0];
      conv_d = 5'd0;
      if (in_a[30:23] >= 8'd143) begin
         conv_r = {in_a[31], mfcda_pkg::ExpInf, 26'd0};
      end else if (in_a[30:23] < 8'd112) begin
         conv_d = 5'(8'd112 - in_a[30:23]);
         conv_m = (in_a[30:23] <= 8'd89) ? 23'd0 : (in_a[22:0] >> conv_d);
         conv_r = {in_a[31], 5'd0, conv_m, 3'd0};
      end else begin
         conv_r = {in_a[31], conv_e[4:0], conv_m, 3'd0};
      end

      // Double.
      dbl_e = in_a[30:26];
      dbl_m = {in_a[25:0], 1'b0};
      if (in_a[30:0] == 31'd0) begin
         dbl_r = in_a;
      end else if (dbl_e == 5'd0) begin
         dbl_r = {in_a[31], 4'd0, dbl_m[26], dbl_m[25:0]};
      end else if (dbl_e < 5'd30) begin
         dbl_r = {in_a[31], dbl_e + 5'd1, in_a[25:0]};
      end else begin
         dbl_r = {in_a[31], mfcda_pkg::ExpInf, 26'd0};
      end

      // Add alignment.
      ea = in_a[30:26];
      eb = in_b[30:26];
      ha = {(ea != 5'd0), in_a[25:0]};
      hb = {(eb != 5'd0), in_b[25:0]};
      ma_in = ha;
      mb_in = hb;
      if (ea < eb) begin
         align_dist = eb - ea;
         ma_in      = (align_dist >= 5'd27) ? 27'd0 : (ha >> align_dist);
         exp_in     = eb;
      end else begin
         align_dist = ea - eb;
         mb_in      = (align_dist >= 5'd27) ? 27'd0 : (hb >> align_dist);
         exp_in     = ea;
      end

      is_add_in = (in_action == mfcda_pkg::ACT_ADD);
      unique case (in_action)
         mfcda_pkg::ACT_CONVERT: direct_in = conv_r;
         mfcda_pkg::ACT_DOUBLE:  direct_in = dbl_r;
         default:                direct_in = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         is_add_ff <= is_add_in;
         direct_ff <= direct_in;
         sa_ff     <= in_a[31];
         sb_ff     <= in_b[31];
         exp_ff    <= exp_in;
         ma_ff     <= ma_in;
         mb_ff     <= mb_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_is_add = is_add_ff;
   assign out_direct = direct_ff;
   assign out_sa     = sa_ff;
   assign out_sb     = sb_ff;
   assign out_exp    = exp_ff;
   assign out_ma     = ma_ff;
   assign out_mb     = mb_ff;

endmodule

`default_nettype wire

[hdl/mfcda_sum.sv]
// ----------------------------------------------------------------------------
// mfcda_sum
// Stage 2: adds or subtracts the aligned magnitudes and counts leading zeros.
// ----------------------------------------------------------------------------
`default_nettype none

module mfcda_sum (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic                 in_valid,
   input  wire logic                 in_is_add,
   input  wire logic [31:0]          in_direct,
   input  wire logic                 in_sa,
   input  wire logic                 in_sb,
   input  wire logic [4:0]           in_exp,
   input  wire logic [26:0]          in_ma,
   input  wire logic [26:0]          in_mb,
   output      logic                 out_valid,
   output      logic                 out_is_add,
   output      logic [31:0]          out_direct,
   output      mfcda_pkg::sum_type   out_sum,
   output      logic [4:0]           out_lz
);

   logic                valid_ff;
   logic                is_add_ff;
   logic [31:0]         direct_ff;
   mfcda_pkg::sum_type  sum_ff, sum_in;
   logic [4:0]          lz_ff, lz_in;

   always_comb begin
      sum_in.exp = in_exp;
      if (in_sa == in_sb) begin
         sum_in.mag  = {1'b0, in_ma} + {1'b0, in_mb};
         sum_in.sign = in_sa;
      end else if (in_ma >= in_mb) begin
         sum_in.mag  = {1'b0, in_ma - in_mb};
         sum_in.sign = in_sa;
      end else begin
         sum_in.mag  = {1'b0, in_mb - in_ma};
         sum_in.sign = in_sb;
      end
      // Distance from bit 26 to the leading one. A zero sum gives 31 so that
      // the left shift always runs the exponent down to zero.
      lz_in = 5'd31;
      for (int i = 0; i <= 26; i++) begin
         if (sum_in.mag[i]) lz_in = 5'(26 - i);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         is_add_ff <= in_is_add;
         direct_ff <= in_direct;
         sum_ff    <= sum_in;
         lz_ff     <= lz_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_is_add = is_add_ff;
   assign out_direct = direct_ff;
   assign out_sum    = sum_ff;
   assign out_lz     = lz_ff;

endmodule

`default_nettype wire

[hdl/mfcda_norm.sv]
// ----------------------------------------------------------------------------
// mfcda_norm
// Stage 3: normalizes the add result, passes convert and double results through, and registers the output word.
// ----------------------------------------------------------------------------
`default_nettype none

module mfcda_norm (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic                 in_valid,
   input  wire logic                 in_is_add,
   input  wire logic [31:0]          in_direct,
   input  wire mfcda_pkg::sum_type   in_sum,
   input  wire logic [4:0]           in_lz,
   output      logic                 out_valid,
   output      logic [31:0]          out_result
);

   logic        valid_ff;
   logic [31:0] result_ff, result_in;
   logic [27:0] rm;
   logic [5:0]  re;
   logic [4:0]  shift;

   always_comb begin
      rm    = in_sum.mag;
      re    = {1'b0, in_sum.exp};
      shift = 5'd0;
      if (rm[27] && in_sum.exp < mfcda_pkg::ExpInf) begin
         // One right step suffices since the sum stays below 2^28.
         rm = rm >> 1;
         re = re + 6'd1;
      end else if (in_sum.exp != 5'd0 && in_sum.exp < mfcda_pkg::ExpInf && !rm[26]) begin
         shift = (in_lz < in_sum.exp) ? in_lz : in_sum.exp;
         rm    = rm << shift;
         re    = re - {1'b0, shift};
      end
      if (re >= 6'd31) begin
         result_in = {in_sum.sign, mfcda_pkg::ExpInf, 26'd0};
      end else if (re != 6'd0) begin
         result_in = {in_sum.sign, re[4:0], rm[25:0]};
      end else begin
         // Exponent 0: bit 26 lands in the exponent's low bit.
         result_in = {in_sum.sign, 4'd0, rm[26:0]};
      end
      if (!in_is_add) result_in = in_direct;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

`default_nettype wire

[hdl/minifloat_convert_double_add_unit.sv]
// ----------------------------------------------------------------------------
// minifloat_convert_double_add_unit
// Convert, double and add for a 1/5/26 custom float format.
// ----------------------------------------------------------------------------
// Usage:
//   A request carries req_action, req_operand_a and req_operand_b and is
//   taken when req_valid is high and req_stall is low. Each request gives one
//   response on rsp_result_value, offered with rsp_valid until the receiver
//   holds rsp_stall low.
//   The pipeline has three register stages: align, sum with leading-zero
//   count, and normalize. One request is taken every cycle while req_stall
//   is low.
//   When rsp_stall is high and the last stage holds a response, the whole
//   pipeline freezes and req_stall is raised; nothing is dropped or repeated.
//   Empty stages freeze as well, so a bubble is not squeezed out by a stall.
//   Reset clears all valid bits; the pipeline is empty afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module minifloat_convert_double_add_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [31:0] req_operand_a,
   input  wire logic [31:0] req_operand_b,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [31:0] rsp_result_value
);

   logic               advance;
   logic               s1_valid, s1_is_add, s1_sa, s1_sb;
   logic [31:0]        s1_direct;
   logic [4:0]         s1_exp;
   logic [26:0]        s1_ma, s1_mb;
   logic               s2_valid, s2_is_add;
   logic [31:0]        s2_direct;
   mfcda_pkg::sum_type s2_sum;
   logic [4:0]         s2_lz;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   mfcda_align u_align (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(req_valid), .in_action(req_action),
      .in_a(req_operand_a), .in_b(req_operand_b),
      .out_valid(s1_valid), .out_is_add(s1_is_add), .out_direct(s1_direct),
      .out_sa(s1_sa), .out_sb(s1_sb), .out_exp(s1_exp),
      .out_ma(s1_ma), .out_mb(s1_mb)
   );

   mfcda_sum u_sum (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(s1_valid), .in_is_add(s1_is_add), .in_direct(s1_direct),
      .in_sa(s1_sa), .in_sb(s1_sb), .in_exp(s1_exp),
      .in_ma(s1_ma), .in_mb(s1_mb),
      .out_valid(s2_valid), .out_is_add(s2_is_add), .out_direct(s2_direct),
      .out_sum(s2_sum), .out_lz(s2_lz)
   );

   mfcda_norm u_norm (
      .clock(clock), .reset(reset), .advance(advance),
      .in_valid(s2_valid), .in_is_add(s2_is_add), .in_direct(s2_direct),
      .in_sum(s2_sum), .in_lz(s2_lz),
      .out_valid(rsp_valid), .out_result(rsp_result_value)
   );

endmodule

`default_nettype wire

[hdl/mfcda_checker.sv]
// ----------------------------------------------------------------------------
// mfcda_checker
// Port-level checks for the minifloat convert/double/add unit.
// ----------------------------------------------------------------------------
`default_nettype none

module mfcda_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_result_value
);

   // The input side stalls exactly when a response is held back.
   a_stall_follows: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("req_stall does not track the held response");

   // A held response keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value))
      else $error("held response changed");

   // A request accepted into an empty, moving pipeline emerges after the align, sum and normalize registers.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall ##1 !req_stall ##1 !req_stall |=> rsp_valid)
      else $error("response missing after three cycles");

   // Nothing comes out right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind minifloat_convert_double_add_unit mfcda_checker u_mfcda_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_result_value(rsp_result_value)
);

`default_nettype wire
